// ===== rtl/core/mec_pkg.sv =====
// mec_pkg: shared constants and the token type that travels down the cell row
// of the majority element counter. No dependencies.
`default_nettype none

package mec_pkg;

	localparam int ENTRIES    = 64;
	localparam int COUNT_BITS = 16;
	localparam int VALUE_BITS = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// One item on its way through the row.
	// done: some cell already matched or stored the value
	// count: the entry count after this item, valid when done is set
	typedef struct packed {
		logic                         vld;
		logic                         last;
		logic                         done;
		logic signed [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0]        count;
	} mec_token_t;

endpackage

`default_nettype wire

// ===== rtl/core/majority_element_counter.sv =====
// majority_element_counter: top level; row of mec_cell entries feeding mec_tally.
// Depends on mec_pkg, mec_cell, mec_tally.
//
// Streams signed 32-bit values, one item per clock, the last of each array
// flagged on s_tlast. Each item walks a row of 64 cells, one cell per cycle;
// every cell holds one distinct value and its count, so an item either
// matches its cell, claims the first empty one, or falls off the end (table
// full, overflow). One result per array appears on the master side once the
// last item has passed the first cell, the other 63 cells and the result
// register (the first cell loads at the edge that accepts it); the next array may
// follow immediately, since the last item clears each cell as it passes.
// Throughput is one item per cycle; the whole row stalls only while a result
// waits on m_tready.
`default_nettype none

module majority_element_counter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value
	input  wire         s_tlast,   // last_item
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata    // [0] has_majority, [1] overflowed, [7:2] zero
);
	import mec_pkg::*;

	mec_token_t tok [ENTRIES+1];
	logic       adv;
	logic       res_majority;
	logic       res_overflow;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		tok[0].vld   = s_tvalid;
		tok[0].last  = s_tlast;
		tok[0].done  = 1'b0;
		tok[0].value = s_tdata;
		tok[0].count = '0;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		mec_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	mec_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.tok          (tok[ENTRIES]),
		.res_vld      (m_tvalid),
		.res_majority (res_majority),
		.res_overflow (res_overflow)
	);

	assign m_tdata = {6'b0, res_overflow, res_majority};

endmodule

`default_nettype wire

// ===== rtl/core/mec_cell.sv =====
// mec_cell: one table entry (key, count, valid) plus the token stage that
// hands the item on to the next cell. Depends on mec_pkg.
`default_nettype none

module mec_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  mec_pkg::mec_token_t tok_in,
	output mec_pkg::mec_token_t tok_out
);
	import mec_pkg::*;

	logic signed [VALUE_BITS-1:0] key_q;
	logic [COUNT_BITS-1:0]        count_q;
	logic                         valid_q;
	mec_token_t                   tok_q;

	logic                  open;
	logic                  hit;
	logic                  ins;
	logic [COUNT_BITS-1:0] new_count;

	assign open = tok_in.vld && !tok_in.done;
	assign hit  = open && valid_q && (key_q == tok_in.value);
	// entries fill from the low end, so the first empty cell is the free slot
	assign ins  = open && !valid_q;

	always_comb begin
		if (hit) begin
			new_count = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
		end else begin
			new_count = {{(COUNT_BITS-1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			key_q   <= '0;
			count_q <= '0;
			tok_q   <= '0;
		end else if (adv) begin
			tok_q.vld   <= tok_in.vld;
			tok_q.last  <= tok_in.last;
			tok_q.value <= tok_in.value;
			tok_q.done  <= tok_in.done || hit || ins;
			tok_q.count <= (hit || ins) ? new_count : tok_in.count;
			// the last item of an array wipes each entry as it passes
			if (tok_in.vld) begin
				valid_q <= tok_in.last ? 1'b0 : (valid_q || ins);
			end
			if (ins) begin
				key_q <= tok_in.value;
			end
			if (hit || ins) begin
				count_q <= new_count;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ===== rtl/core/mec_tally.sv =====
// mec_tally: end of the cell row; keeps item total, largest count and the
// overflow flag, and registers the result. Depends on mec_pkg.
`default_nettype none

module mec_tally (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  mec_pkg::mec_token_t tok,
	output logic                res_vld,
	output logic                res_majority,
	output logic                res_overflow
);
	import mec_pkg::*;

	logic [COUNT_BITS-1:0] items_q;
	logic [COUNT_BITS-1:0] largest_q;
	logic                  ovf_q;
	logic                  res_vld_q;
	logic                  res_majority_q;
	logic                  res_overflow_q;

	logic [COUNT_BITS-1:0] items_n;
	logic [COUNT_BITS-1:0] largest_n;
	logic                  ovf_n;

	always_comb begin
		items_n   = (items_q == COUNT_MAX) ? items_q : items_q + 1'b1;
		largest_n = (tok.done && tok.count > largest_q) ? tok.count : largest_q;
		// no cell took the value (table full), or the item total saturated
		ovf_n     = ovf_q || !tok.done || (items_q == COUNT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q   <= '0;
			largest_q <= '0;
			ovf_q     <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= tok.vld && tok.last;
			if (tok.vld) begin
				if (tok.last) begin
					items_q   <= '0;
					largest_q <= '0;
					ovf_q     <= 1'b0;
				end else begin
					items_q   <= items_n;
					largest_q <= largest_n;
					ovf_q     <= ovf_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_majority_q <= largest_n > (items_n >> 1);
			res_overflow_q <= ovf_n;
		end
	end

	assign res_vld      = res_vld_q;
	assign res_majority = res_majority_q;
	assign res_overflow = res_overflow_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		largest_q <= items_q)
		else $error("largest count above item total");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && tok.vld && tok.last) |=> (items_q == '0 && largest_q == '0 && !ovf_q))
		else $error("state not cleared after last item");

	a_miss_sets_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && tok.vld && !tok.done && !tok.last) |=> ovf_q)
		else $error("unplaced item did not flag overflow");

endmodule

`default_nettype wire
